### sv/cpi_pkg.sv
package cpi_pkg;

   // default port width of coordinates
   localparam int COORD_WIDTH_DEFAULT = 16;

   // core arithmetic widths (the core always works on Q11.4 words)
   localparam int CORE_W  = 16;
   localparam int RAD_W   = 15;
   localparam int MAG_W   = 16;
   localparam int D2_W    = 33;
   localparam int KMAG_W  = 32;
   localparam int RADIC_W = 64;
   localparam int ROOT_W  = 32;
   localparam int REM_W   = 34;
   localparam int PROD_W  = 48;
   localparam int NUM_W   = 49;
   localparam int QUO_W   = 16;
   localparam int DEN_W   = 34;
   localparam int SUM_W   = 20;
   localparam int LANES   = 4;

   // lane order of the four divisions
   localparam int LANE_FX = 0;
   localparam int LANE_FY = 1;
   localparam int LANE_GX = 2;
   localparam int LANE_GY = 3;

   // values that ride alongside the square root and the dividers
   typedef struct packed {
      logic                     found;
      logic signed [CORE_W-1:0] x1;
      logic signed [CORE_W-1:0] y1;
      logic [MAG_W-1:0]         dxm;
      logic [MAG_W-1:0]         dym;
      logic                     dxn;
      logic                     dyn;
      logic [KMAG_W-1:0]        kmag;
      logic                     kneg;
      logic [D2_W-1:0]          d2;
   } carry_type;

endpackage

### sv/circle_pair_intersection.sv
// Circle pair intersection, Q11.4 fixed point.
//
// Input channel req_*: one word holds two circles (centre x, y and radius).
// Result channel rsp_*: one word per input word, in order: rsp_found and the
// two crossing points f+g (plus) and f-g (minus). When the circles do not
// meet, or share a centre, rsp_found is low and all coordinates are zero.
//
// The pipeline holds a 32-step digit-by-digit square root of the 64-bit
// radicand and the 16-step restoring dividers (four lanes, one per coordinate
// term), one step a stage. Throughput: one word per cycle while req_ready is high.
//
// Stalls: the whole pipeline moves as one. Its last stage feeds an output
// register plus one spare register, so words keep entering while a result
// waits on rsp_ready; req_ready drops only once the spare is full.
//
// Reset (synchronous, active high) clears every valid bit, including those of
// the output and spare registers; payload registers are not reset.
module circle_pair_intersection #(
   parameter int COORD_WIDTH = cpi_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic [COORD_WIDTH-2:0]        req_first_radius,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   input  logic [COORD_WIDTH-2:0]        req_second_radius,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic signed [COORD_WIDTH-1:0] rsp_plus_x,
   output logic signed [COORD_WIDTH-1:0] rsp_plus_y,
   output logic signed [COORD_WIDTH-1:0] rsp_minus_x,
   output logic signed [COORD_WIDTH-1:0] rsp_minus_y
);

   localparam int W    = COORD_WIDTH;
   localparam int DROP = (W > cpi_pkg::CORE_W) ? (W - cpi_pkg::CORE_W) : 0;
   localparam int IW   = (W > cpi_pkg::CORE_W) ? W : cpi_pkg::CORE_W;
   localparam int LIM  = W - 1 - DROP;
   localparam int SW   = cpi_pkg::SUM_W;
   localparam int NSQ  = cpi_pkg::ROOT_W;
   localparam int NDV  = cpi_pkg::QUO_W;
   localparam int NL   = cpi_pkg::LANES;

   localparam logic signed [SW-1:0] HI_C   = SW'((1 << LIM) - 1);
   localparam logic signed [SW-1:0] LO_C   = SW'(-(1 << LIM));
   localparam logic signed [W-1:0]  OUT_HI = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0]  OUT_LO = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic                found;
      logic signed [W-1:0] px;
      logic signed [W-1:0] py;
      logic signed [W-1:0] mx;
      logic signed [W-1:0] my;
   } word_type;

   // port coordinate to core coordinate (floor on dropped bits)
   function automatic logic signed [15:0] conv_xy(input logic signed [W-1:0] v);
      logic signed [IW-1:0] w;
      w = IW'(v);
      return 16'(w >>> DROP);
   endfunction

   function automatic logic [14:0] conv_r(input logic [W-2:0] v);
      logic [IW-2:0] w;
      w = (IW-1)'(v);
      return 15'(w >> DROP);
   endfunction

   // scale back up and saturate to the port range
   function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
      logic signed [51:0] w;
      w = 52'(v);
      w = w <<< DROP;
      if (v > HI_C) return OUT_HI;
      else if (v < LO_C) return OUT_LO;
      else return w[W-1:0];
   endfunction

   logic ce;

   // ---------------- stage A: convert, differences ----------------
   logic               a_v_ff;
   logic signed [15:0] a_x1_ff, a_y1_ff, a_x1_in, a_y1_in, a_x2_in, a_y2_in;
   logic signed [16:0] a_dx_ff, a_dy_ff, a_dx_in, a_dy_in;
   logic [14:0]        a_r1_ff, a_r2_ff, a_r1_in, a_r2_in;
   logic [15:0]        a_rs_ff, a_rs_in;
   logic signed [15:0] a_rd_ff, a_rd_in;

   always_comb begin
      a_x1_in = conv_xy(req_first_x);
      a_y1_in = conv_xy(req_first_y);
      a_x2_in = conv_xy(req_second_x);
      a_y2_in = conv_xy(req_second_y);
      a_r1_in = conv_r(req_first_radius);
      a_r2_in = conv_r(req_second_radius);
      a_dx_in = 17'(a_x2_in) - 17'(a_x1_in);
      a_dy_in = 17'(a_y2_in) - 17'(a_y1_in);
      a_rs_in = 16'(a_r1_in) + 16'(a_r2_in);
      a_rd_in = $signed({1'b0, a_r1_in}) - $signed({1'b0, a_r2_in});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (ce) begin
         a_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         a_x1_ff <= a_x1_in;
         a_y1_ff <= a_y1_in;
         a_dx_ff <= a_dx_in;
         a_dy_ff <= a_dy_in;
         a_r1_ff <= a_r1_in;
         a_r2_ff <= a_r2_in;
         a_rs_ff <= a_rs_in;
         a_rd_ff <= a_rd_in;
      end
   end

   // ---------------- stage B: squares ----------------
   logic               b_v_ff;
   logic signed [15:0] b_x1_ff, b_y1_ff;
   logic [31:0]        b_dx2_ff, b_dy2_ff, b_rs2_ff, b_dx2_in, b_dy2_in, b_rs2_in;
   logic [29:0]        b_rd2_ff, b_r1s_ff, b_r2s_ff, b_rd2_in, b_r1s_in, b_r2s_in;
   logic [15:0]        b_dxm_ff, b_dym_ff, b_dxm_in, b_dym_in;
   logic               b_dxn_ff, b_dyn_ff;

   always_comb begin
      logic signed [33:0] sdx, sdy;
      logic signed [31:0] srd;
      sdx      = a_dx_ff * a_dx_ff;
      sdy      = a_dy_ff * a_dy_ff;
      srd      = a_rd_ff * a_rd_ff;
      b_dx2_in = sdx[31:0];
      b_dy2_in = sdy[31:0];
      b_rd2_in = srd[29:0];
      b_rs2_in = 32'(a_rs_ff) * 32'(a_rs_ff);
      b_r1s_in = 30'(a_r1_ff) * 30'(a_r1_ff);
      b_r2s_in = 30'(a_r2_ff) * 30'(a_r2_ff);
      b_dxm_in = a_dx_ff[16] ? 16'(-a_dx_ff) : 16'(a_dx_ff);
      b_dym_in = a_dy_ff[16] ? 16'(-a_dy_ff) : 16'(a_dy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (ce) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         b_x1_ff  <= a_x1_ff;
         b_y1_ff  <= a_y1_ff;
         b_dx2_ff <= b_dx2_in;
         b_dy2_ff <= b_dy2_in;
         b_rs2_ff <= b_rs2_in;
         b_rd2_ff <= b_rd2_in;
         b_r1s_ff <= b_r1s_in;
         b_r2s_ff <= b_r2s_in;
         b_dxm_ff <= b_dxm_in;
         b_dym_ff <= b_dym_in;
         b_dxn_ff <= a_dx_ff[16];
         b_dyn_ff <= a_dy_ff[16];
      end
   end

   // ---------------- stage C: squared distance ----------------
   logic               c_v_ff;
   logic signed [15:0] c_x1_ff, c_y1_ff;
   logic [32:0]        c_d2_ff, c_d2_in;
   logic signed [30:0] c_rdf_ff, c_rdf_in;
   logic [31:0]        c_rs2_ff;
   logic [29:0]        c_rd2_ff, c_r1s_ff;
   logic [15:0]        c_dxm_ff, c_dym_ff;
   logic               c_dxn_ff, c_dyn_ff;

   always_comb begin
      c_d2_in  = 33'(b_dx2_ff) + 33'(b_dy2_ff);
      c_rdf_in = $signed({1'b0, b_r1s_ff}) - $signed({1'b0, b_r2s_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (ce) begin
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         c_x1_ff  <= b_x1_ff;
         c_y1_ff  <= b_y1_ff;
         c_d2_ff  <= c_d2_in;
         c_rdf_ff <= c_rdf_in;
         c_rs2_ff <= b_rs2_ff;
         c_rd2_ff <= b_rd2_ff;
         c_r1s_ff <= b_r1s_ff;
         c_dxm_ff <= b_dxm_ff;
         c_dym_ff <= b_dym_ff;
         c_dxn_ff <= b_dxn_ff;
         c_dyn_ff <= b_dyn_ff;
      end
   end

   // ---------------- stage D: meet test, K, d2*r1^2 ----------------
   logic               d_v_ff, d_found_ff, d_found_in;
   logic signed [15:0] d_x1_ff, d_y1_ff;
   logic [32:0]        d_d2_ff;
   logic signed [34:0] d_k_ff, d_k_in;
   logic [61:0]        d_fullh_ff, d_fullh_in;
   logic [15:0]        d_dxm_ff, d_dym_ff;
   logic               d_dxn_ff, d_dyn_ff;

   always_comb begin
      d_found_in = (c_d2_ff != '0) && (c_d2_ff <= 33'(c_rs2_ff))
                   && (c_d2_ff >= 33'(c_rd2_ff));
      d_k_in     = $signed({2'b00, c_d2_ff}) + 35'(c_rdf_ff);
      d_fullh_in = 62'(c_d2_ff[31:0]) * 62'(c_r1s_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (ce) begin
         d_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         d_found_ff <= d_found_in;
         d_x1_ff    <= c_x1_ff;
         d_y1_ff    <= c_y1_ff;
         d_d2_ff    <= c_d2_ff;
         d_k_ff     <= d_k_in;
         d_fullh_ff <= d_fullh_in;
         d_dxm_ff   <= c_dxm_ff;
         d_dym_ff   <= c_dym_ff;
         d_dxn_ff   <= c_dxn_ff;
         d_dyn_ff   <= c_dyn_ff;
      end
   end

   // ---------------- stage E: |K|, gather carried word ----------------
   logic                e_v_ff;
   cpi_pkg::carry_type  e_c_ff, e_c_in;
   logic [61:0]         e_fullh_ff;

   always_comb begin
      e_c_in.found = d_found_ff;
      e_c_in.x1    = d_x1_ff;
      e_c_in.y1    = d_y1_ff;
      e_c_in.dxm   = d_dxm_ff;
      e_c_in.dym   = d_dym_ff;
      e_c_in.dxn   = d_dxn_ff;
      e_c_in.dyn   = d_dyn_ff;
      e_c_in.kneg  = d_k_ff[34];
      e_c_in.kmag  = d_k_ff[34] ? 32'(-d_k_ff) : 32'(d_k_ff);
      e_c_in.d2    = d_d2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (ce) begin
         e_v_ff <= d_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         e_c_ff     <= e_c_in;
         e_fullh_ff <= d_fullh_ff;
      end
   end

   // ---------------- stage F: K^2, 4*d2*r1^2 ----------------
   logic               f_v_ff;
   cpi_pkg::carry_type f_c_ff;
   logic [63:0]        f_kk_ff, f_full_ff, f_kk_in;

   assign f_kk_in = 64'(e_c_ff.kmag) * 64'(e_c_ff.kmag);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (ce) begin
         f_v_ff <= e_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         f_c_ff    <= e_c_ff;
         f_kk_ff   <= f_kk_in;
         f_full_ff <= {e_fullh_ff, 2'b00};
      end
   end

   // ---------------- square root pipeline (index 0 = radicand stage) ----------------
   logic               sq_v_ff    [0:NSQ];
   cpi_pkg::carry_type sq_c_ff    [0:NSQ];
   logic [63:0]        sq_rad_ff  [0:NSQ];
   logic [33:0]        sq_rem_ff  [0:NSQ];
   logic [31:0]        sq_root_ff [0:NSQ];
   logic [63:0]        g_rad_in;

   // clamp a negative radicand to zero
   assign g_rad_in = (f_full_ff > f_kk_ff) ? (f_full_ff - f_kk_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (ce) begin
         sq_v_ff[0] <= f_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         sq_c_ff[0]    <= f_c_ff;
         sq_rad_ff[0]  <= g_rad_in;
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
      end
   end

   // one result bit per stage, two radicand bits brought down each step
   for (genvar j = 0; j < NSQ; j++) begin : g_sq
      logic [33:0] rem_in;
      logic [31:0] root_in;

      always_comb begin
         logic [35:0] trial, tsub;
         trial = {sq_rem_ff[j], sq_rad_ff[j][63-2*j -: 2]};
         tsub  = 36'({sq_root_ff[j], 2'b01});
         if (trial >= tsub) begin
            rem_in  = 34'(trial - tsub);
            root_in = {sq_root_ff[j][30:0], 1'b1};
         end else begin
            rem_in  = trial[33:0];
            root_in = {sq_root_ff[j][30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[j+1] <= 1'b0;
         end else if (ce) begin
            sq_v_ff[j+1] <= sq_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            sq_c_ff[j+1]    <= sq_c_ff[j];
            sq_rad_ff[j+1]  <= sq_rad_ff[j];
            sq_rem_ff[j+1]  <= rem_in;
            sq_root_ff[j+1] <= root_in;
         end
      end
   end

   // ---------------- stage P: numerators ----------------
   logic               p_v_ff;
   cpi_pkg::carry_type p_c_ff;
   logic [47:0]        p_n_ff [0:NL-1];
   logic [47:0]        p_n_in [0:NL-1];
   logic [NL-1:0]      p_sg_ff, p_sg_in;

   always_comb begin
      cpi_pkg::carry_type c;
      logic [31:0]        s;
      c = sq_c_ff[NSQ];
      s = sq_root_ff[NSQ];
      p_n_in[cpi_pkg::LANE_FX]  = 48'(c.kmag) * 48'(c.dxm);
      p_n_in[cpi_pkg::LANE_FY]  = 48'(c.kmag) * 48'(c.dym);
      p_n_in[cpi_pkg::LANE_GX]  = 48'(s) * 48'(c.dym);
      p_n_in[cpi_pkg::LANE_GY]  = 48'(s) * 48'(c.dxm);
      p_sg_in[cpi_pkg::LANE_FX] = c.kneg ^ c.dxn;
      p_sg_in[cpi_pkg::LANE_FY] = c.kneg ^ c.dyn;
      p_sg_in[cpi_pkg::LANE_GX] = c.dyn;
      p_sg_in[cpi_pkg::LANE_GY] = ~c.dxn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else if (ce) begin
         p_v_ff <= sq_v_ff[NSQ];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         p_c_ff  <= sq_c_ff[NSQ];
         p_n_ff  <= p_n_in;
         p_sg_ff <= p_sg_in;
      end
   end

   // ---------------- divider pipeline (index 0 = rounding add) ----------------
   logic               dv_v_ff   [0:NDV];
   cpi_pkg::carry_type dv_c_ff   [0:NDV];
   logic [NL-1:0]      dv_sg_ff  [0:NDV];
   logic [33:0]        dv_rem_ff [0:NDV][0:NL-1];
   logic [15:0]        dv_lo_ff  [0:NDV][0:NL-1];
   logic [15:0]        dv_q_ff   [0:NDV][0:NL-1];
   logic [33:0]        q_rem_in  [0:NL-1];
   logic [15:0]        q_lo_in   [0:NL-1];

   // adding d2 before dividing by 2*d2 rounds halves away from zero
   always_comb begin
      logic [48:0] num;
      for (int l = 0; l < NL; l++) begin
         num         = 49'(p_n_ff[l]) + 49'(p_c_ff.d2);
         q_rem_in[l] = 34'(num[48:16]);
         q_lo_in[l]  = num[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (ce) begin
         dv_v_ff[0] <= p_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         dv_c_ff[0]   <= p_c_ff;
         dv_sg_ff[0]  <= p_sg_ff;
         dv_rem_ff[0] <= q_rem_in;
         dv_lo_ff[0]  <= q_lo_in;
         for (int l = 0; l < NL; l++) begin
            dv_q_ff[0][l] <= '0;
         end
      end
   end

   // restoring division, one quotient bit per stage in each lane
   for (genvar i = 0; i < NDV; i++) begin : g_dv
      logic [33:0] rem_in [0:NL-1];
      logic [15:0] q_in   [0:NL-1];

      always_comb begin
         logic [34:0] trial, den;
         den = 35'({dv_c_ff[i].d2, 1'b0});
         for (int l = 0; l < NL; l++) begin
            trial = {dv_rem_ff[i][l], dv_lo_ff[i][l][15-i]};
            if (trial >= den) begin
               rem_in[l] = 34'(trial - den);
               q_in[l]   = {dv_q_ff[i][l][14:0], 1'b1};
            end else begin
               rem_in[l] = trial[33:0];
               q_in[l]   = {dv_q_ff[i][l][14:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[i+1] <= 1'b0;
         end else if (ce) begin
            dv_v_ff[i+1] <= dv_v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            dv_c_ff[i+1]   <= dv_c_ff[i];
            dv_sg_ff[i+1]  <= dv_sg_ff[i];
            dv_rem_ff[i+1] <= rem_in;
            dv_lo_ff[i+1]  <= dv_lo_ff[i];
            dv_q_ff[i+1]   <= q_in;
         end
      end
   end

   // ---------------- stage R: signs, foot point ----------------
   logic               r_v_ff, r_found_ff;
   logic signed [18:0] r_fx_ff, r_fy_ff, r_fx_in, r_fy_in;
   logic signed [17:0] r_gx_ff, r_gy_ff;
   logic signed [17:0] r_qs [0:NL-1];

   always_comb begin
      logic signed [17:0] qm;
      for (int l = 0; l < NL; l++) begin
         qm      = $signed({2'b00, dv_q_ff[NDV][l]});
         r_qs[l] = dv_sg_ff[NDV][l] ? -qm : qm;
      end
      r_fx_in = 19'(dv_c_ff[NDV].x1) + 19'(r_qs[cpi_pkg::LANE_FX]);
      r_fy_in = 19'(dv_c_ff[NDV].y1) + 19'(r_qs[cpi_pkg::LANE_FY]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff <= 1'b0;
      end else if (ce) begin
         r_v_ff <= dv_v_ff[NDV];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         r_found_ff <= dv_c_ff[NDV].found;
         r_fx_ff    <= r_fx_in;
         r_fy_ff    <= r_fy_in;
         r_gx_ff    <= r_qs[cpi_pkg::LANE_GX];
         r_gy_ff    <= r_qs[cpi_pkg::LANE_GY];
      end
   end

   // ---------------- stage T: f + g and f - g ----------------
   logic                t_v_ff, t_found_ff;
   logic signed [SW-1:0] t_px_ff, t_py_ff, t_mx_ff, t_my_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_v_ff <= 1'b0;
      end else if (ce) begin
         t_v_ff <= r_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         t_found_ff <= r_found_ff;
         t_px_ff    <= SW'(r_fx_ff) + SW'(r_gx_ff);
         t_py_ff    <= SW'(r_fy_ff) + SW'(r_gy_ff);
         t_mx_ff    <= SW'(r_fx_ff) - SW'(r_gx_ff);
         t_my_ff    <= SW'(r_fy_ff) - SW'(r_gy_ff);
      end
   end

   // ---------------- output register and spare ----------------
   logic     out_vld_ff, out_vld_in, spr_vld_ff, spr_vld_in;
   word_type out_ff, out_in, spr_ff, spr_in, new_word;
   logic     take, incoming;

   assign ce        = ~spr_vld_ff;
   assign req_ready = ce;
   assign take      = out_vld_ff & rsp_ready;
   assign incoming  = ce & t_v_ff;

   always_comb begin
      new_word.found = t_found_ff;
      new_word.px    = t_found_ff ? sat(t_px_ff) : '0;
      new_word.py    = t_found_ff ? sat(t_py_ff) : '0;
      new_word.mx    = t_found_ff ? sat(t_mx_ff) : '0;
      new_word.my    = t_found_ff ? sat(t_my_ff) : '0;
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      spr_vld_in = spr_vld_ff;
      spr_in     = spr_ff;
      priority if (spr_vld_ff) begin
         if (take) begin
            out_in     = spr_ff;
            spr_vld_in = 1'b0;
         end
      end else if (out_vld_ff && !take) begin
         if (incoming) begin
            spr_in     = new_word;
            spr_vld_in = 1'b1;
         end
      end else begin
         out_vld_in = incoming;
         out_in     = new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         spr_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
         spr_vld_ff <= spr_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      spr_ff <= spr_in;
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_found   = out_ff.found;
   assign rsp_plus_x  = out_ff.px;
   assign rsp_plus_y  = out_ff.py;
   assign rsp_minus_x = out_ff.mx;
   assign rsp_minus_y = out_ff.my;

   // ---------------- assertions ----------------
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_plus_x == '0 && rsp_plus_y == '0
                                  && rsp_minus_x == '0 && rsp_minus_y == '0)
      else $error("no-meet word carries non-zero coordinates");

   a_spare_order: assert property (@(posedge clock) disable iff (reset)
      spr_vld_ff |-> out_vld_ff)
      else $error("spare register holds a word while output register is empty");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      dv_v_ff[0] && dv_c_ff[0].found |-> dv_c_ff[0].d2 != '0)
      else $error("divider fed a zero divisor for a meeting pair");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule
